// ===== hdl/lzsd_pkg.sv =====
// Shared types, codes and constants of the LZ sequence decompressor.
`timescale 1ns / 1ps
`default_nettype none

package lzsd_pkg;

	localparam int unsigned WINDOW_BYTES_DEF = 65536;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);
	localparam int unsigned ACCEPT_LIMIT = OUT_DEPTH - 2;

	localparam logic [31:0] MAGIC_WORD = 32'h5250_4D43;
	localparam logic [3:0] MIN_MATCH = 4'd4;
	localparam logic [3:0] NIB_ESCAPE = 4'hF;
	localparam logic [7:0] EXT_MORE = 8'hFF;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_LITEXT,
		PH_LITERAL,
		PH_OFF_LO,
		PH_OFF_HI,
		PH_MLEXT,
		PH_COPY,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_LAST,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_MAGIC,
		ERR_ZERO_SIZE,
		ERR_CAPACITY,
		ERR_LIT_OVERRUN,
		ERR_ZERO_OFFSET,
		ERR_OFFSET_RANGE,
		ERR_MATCH_OVERRUN,
		ERR_SHORT_STREAM,
		ERR_BYTE_IN_COPY
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		err_t        code;
	} res_t;

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
		input logic [7:0] b);
		logic [LEN_W:0] sum;
		sum = {1'b0, a} + {{(LEN_W - 7){1'b0}}, b};
		sat_add = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lz_sequence_decompressor.sv =====
// Top level of the LZ sequence decompressor: stream parser, history memory and output queue.
// Throughput: one slave beat per cycle while s_tready is high, whether a stream byte or a drain tick.
// A result is registered in stage s1 when its beat is accepted and pushed from there into the output queue.
// A copy byte is read from history in the accepting cycle, forwarding the byte written then.
// s_tready is low while the four-entry output queue plus the result in flight reach three.
// Reset is asynchronous and clears all control state; history is not cleared, no pass needed.
`timescale 1ns / 1ps
`default_nettype none

module lz_sequence_decompressor #(
	parameter int unsigned WINDOW_BYTES = lzsd_pkg::WINDOW_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic [0:0]  s_tuser,   // [0] opcode
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
	output logic [1:0]       m_tuser    // [1:0] kind
);

	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam int unsigned SW = lzsd_pkg::DIST_W + 1;
	localparam int unsigned LW = lzsd_pkg::LEN_W;

	logic [7:0] hist_mem [WINDOW_BYTES];
	logic [7:0] rd_q;

	logic [31:0] cap_q;
	lzsd_pkg::phase_t phase_q, phase_d;
	logic [2:0] hdr_q, hdr_d;
	logic [LW-1:0] target_q, target_d;
	logic [LW-1:0] remain_q, remain_d;
	logic [3:0] tok_q, tok_d;
	logic [LW-1:0] lit_q, lit_d;
	logic [lzsd_pkg::DIST_W-1:0] dist_q, dist_d;
	logic [LW-1:0] copy_q, copy_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [lzsd_pkg::DIST_W-1:0] prod_lo_q, prod_lo_d;
	logic prod_big_q, prod_big_d;

	logic accept;
	logic do_put;
	logic fail;
	lzsd_pkg::err_t fail_code;
	logic res_v;
	lzsd_pkg::kind_t res_kind;
	lzsd_pkg::err_t res_code;
	logic [7:0] res_lit;
	logic res_copy;
	logic rd_en;
	logic [SW-1:0] diff;
	logic [AW-1:0] src;
	logic [lzsd_pkg::DIST_W:0] prod_inc;

	logic s1_valid;
	lzsd_pkg::kind_t kind_s1;
	lzsd_pkg::err_t code_s1;
	logic [7:0] lit_s1;
	logic put_s1;
	logic copy_s1;
	logic [AW-1:0] waddr_s1;
	logic fwd_s1;
	logic [7:0] fwd_data_s1;
	logic [7:0] wr_data;

	lzsd_pkg::res_t push_res;
	lzsd_pkg::res_t pop_res;
	logic [lzsd_pkg::OUT_LEVEL_W-1:0] level;

	assign s_tready = ((level + lzsd_pkg::OUT_LEVEL_W'(s1_valid))
		<= lzsd_pkg::OUT_LEVEL_W'(lzsd_pkg::ACCEPT_LIMIT));
	assign accept = s_tvalid & s_tready;

	assign diff = SW'(ptr_q) - SW'(dist_q);
	assign src = diff[SW-1] ? AW'(diff + SW'(WINDOW_BYTES)) : AW'(diff);
	assign prod_inc = {1'b0, prod_lo_q} + 1'b1;

	always_comb begin
		phase_d = phase_q;
		hdr_d = hdr_q;
		target_d = target_q;
		remain_d = remain_q;
		tok_d = tok_q;
		lit_d = lit_q;
		dist_d = dist_q;
		copy_d = copy_q;
		ptr_d = ptr_q;
		prod_lo_d = prod_lo_q;
		prod_big_d = prod_big_q;
		do_put = 1'b0;
		fail = 1'b0;
		fail_code = lzsd_pkg::ERR_NONE;
		res_v = 1'b0;
		res_kind = lzsd_pkg::KIND_DATA;
		res_code = lzsd_pkg::ERR_NONE;
		res_lit = '0;
		res_copy = 1'b0;
		rd_en = 1'b0;
		if (accept && phase_q != lzsd_pkg::PH_DONE && phase_q != lzsd_pkg::PH_ERROR) begin
			if (s_tuser[0]) begin
				if (phase_q == lzsd_pkg::PH_COPY) begin
					rd_en = 1'b1;
					res_copy = 1'b1;
					do_put = 1'b1;
					copy_d = copy_q - 1'b1;
					if (copy_q == LW'(1)) begin
						phase_d = lzsd_pkg::PH_TOKEN;
					end
				end
			end else begin
				case (phase_q)
					lzsd_pkg::PH_HEADER: begin
						if (!hdr_q[2] && s_tdata != lzsd_pkg::MAGIC_WORD[8*hdr_q[1:0] +: 8]) begin
							fail = 1'b1;
							fail_code = lzsd_pkg::ERR_MAGIC;
						end else begin
							if (hdr_q[2]) begin
								target_d[8*hdr_q[1:0] +: 8] = s_tdata;
							end
							if (hdr_q != 3'd7) begin
								hdr_d = hdr_q + 1'b1;
							end else if (target_d == '0) begin
								fail = 1'b1;
								fail_code = lzsd_pkg::ERR_ZERO_SIZE;
							end else if (target_d > cap_q) begin
								fail = 1'b1;
								fail_code = lzsd_pkg::ERR_CAPACITY;
							end else begin
								phase_d = lzsd_pkg::PH_TOKEN;
								remain_d = target_d;
							end
						end
					end
					lzsd_pkg::PH_TOKEN: begin
						tok_d = s_tdata[3:0];
						lit_d = LW'(s_tdata[7:4]);
						if (s_tdata[7:4] == lzsd_pkg::NIB_ESCAPE) begin
							phase_d = lzsd_pkg::PH_LITEXT;
						end else if (lit_d > remain_q) begin
							fail = 1'b1;
							fail_code = lzsd_pkg::ERR_LIT_OVERRUN;
						end else begin
							phase_d = (lit_d != '0) ? lzsd_pkg::PH_LITERAL : lzsd_pkg::PH_OFF_LO;
						end
					end
					lzsd_pkg::PH_LITEXT: begin
						lit_d = lzsd_pkg::sat_add(lit_q, s_tdata);
						if (s_tdata != lzsd_pkg::EXT_MORE) begin
							if (lit_d > remain_q) begin
								fail = 1'b1;
								fail_code = lzsd_pkg::ERR_LIT_OVERRUN;
							end else begin
								phase_d = (lit_d != '0) ? lzsd_pkg::PH_LITERAL
									: lzsd_pkg::PH_OFF_LO;
							end
						end
					end
					lzsd_pkg::PH_LITERAL: begin
						lit_d = lit_q - 1'b1;
						do_put = 1'b1;
						res_lit = s_tdata;
						if (lit_q == LW'(1)) begin
							phase_d = lzsd_pkg::PH_OFF_LO;
						end
					end
					lzsd_pkg::PH_OFF_LO: begin
						dist_d = {8'h00, s_tdata};
						phase_d = lzsd_pkg::PH_OFF_HI;
					end
					lzsd_pkg::PH_OFF_HI: begin
						dist_d = {s_tdata, dist_q[7:0]};
						copy_d = LW'(tok_q) + LW'(lzsd_pkg::MIN_MATCH);
						if (dist_d == '0) begin
							fail = 1'b1;
							fail_code = lzsd_pkg::ERR_ZERO_OFFSET;
						end else if ((!prod_big_q && dist_d > prod_lo_q)
							|| ({1'b0, dist_d} > SW'(WINDOW_BYTES))) begin
							fail = 1'b1;
							fail_code = lzsd_pkg::ERR_OFFSET_RANGE;
						end else if (tok_q == lzsd_pkg::NIB_ESCAPE) begin
							phase_d = lzsd_pkg::PH_MLEXT;
						end else if (copy_d > remain_q) begin
							fail = 1'b1;
							fail_code = lzsd_pkg::ERR_MATCH_OVERRUN;
						end else begin
							phase_d = lzsd_pkg::PH_COPY;
						end
					end
					lzsd_pkg::PH_MLEXT: begin
						copy_d = lzsd_pkg::sat_add(copy_q, s_tdata);
						if (s_tdata != lzsd_pkg::EXT_MORE) begin
							if (copy_d > remain_q) begin
								fail = 1'b1;
								fail_code = lzsd_pkg::ERR_MATCH_OVERRUN;
							end else begin
								phase_d = lzsd_pkg::PH_COPY;
							end
						end
					end
					default: begin
						fail = 1'b1;
						fail_code = lzsd_pkg::ERR_BYTE_IN_COPY;
					end
				endcase
			end

			if (do_put) begin
				res_v = 1'b1;
				remain_d = remain_q - 1'b1;
				ptr_d = (ptr_q == AW'(WINDOW_BYTES - 1)) ? '0 : ptr_q + 1'b1;
				prod_lo_d = prod_inc[lzsd_pkg::DIST_W-1:0];
				prod_big_d = prod_big_q | prod_inc[lzsd_pkg::DIST_W];
				if (remain_q == LW'(1)) begin
					phase_d = lzsd_pkg::PH_DONE;
					res_kind = lzsd_pkg::KIND_LAST;
				end
			end

			if (fail) begin
				phase_d = lzsd_pkg::PH_ERROR;
				res_v = 1'b1;
				res_kind = lzsd_pkg::KIND_ERROR;
				res_code = fail_code;
			end else if (!s_tuser[0] && s_tlast && phase_d != lzsd_pkg::PH_DONE
				&& !(phase_d == lzsd_pkg::PH_COPY && copy_d == remain_d)) begin
				phase_d = lzsd_pkg::PH_ERROR;
				do_put = 1'b0;
				res_v = 1'b1;
				res_kind = lzsd_pkg::KIND_ERROR;
				res_code = lzsd_pkg::ERR_SHORT_STREAM;
				res_lit = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
			phase_q <= lzsd_pkg::PH_HEADER;
			hdr_q <= '0;
			target_q <= '0;
			remain_q <= '0;
			tok_q <= '0;
			lit_q <= '0;
			dist_q <= '0;
			copy_q <= '0;
			ptr_q <= '0;
			prod_lo_q <= '0;
			prod_big_q <= 1'b0;
			s1_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			phase_q <= phase_d;
			hdr_q <= hdr_d;
			target_q <= target_d;
			remain_q <= remain_d;
			tok_q <= tok_d;
			lit_q <= lit_d;
			dist_q <= dist_d;
			copy_q <= copy_d;
			ptr_q <= ptr_d;
			prod_lo_q <= prod_lo_d;
			prod_big_q <= prod_big_d;
			s1_valid <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= res_kind;
		code_s1 <= res_code;
		lit_s1 <= res_lit;
		put_s1 <= do_put;
		copy_s1 <= res_copy;
		waddr_s1 <= ptr_q;
		fwd_s1 <= s1_valid && put_s1 && (waddr_s1 == src);
		fwd_data_s1 <= wr_data;
	end

	assign wr_data = copy_s1 ? (fwd_s1 ? fwd_data_s1 : rd_q) : lit_s1;

	always_ff @(posedge clk) begin
		if (s1_valid && put_s1) begin
			hist_mem[waddr_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= hist_mem[src];
		end
	end

	assign push_res.kind = kind_s1;
	assign push_res.data = wr_data;
	assign push_res.code = code_s1;

	lzsd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid),
		.push_res  (push_res),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_res   (pop_res),
		.level     (level)
	);

	assign m_tdata = {4'h0, pop_res.code, pop_res.data};
	assign m_tuser = pop_res.kind;

endmodule

`default_nettype wire

// ===== hdl/lzsd_out_fifo.sv =====
// Small output queue that decouples result beats from the master-side handshake.
`timescale 1ns / 1ps
`default_nettype none

module lzsd_out_fifo (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire lzsd_pkg::res_t                     push_res,
	output logic                                    pop_valid,
	input  wire logic                               pop_ready,
	output lzsd_pkg::res_t                          pop_res,
	output logic [lzsd_pkg::OUT_LEVEL_W-1:0]        level
);

	lzsd_pkg::res_t entry_q [lzsd_pkg::OUT_DEPTH];
	logic [lzsd_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [lzsd_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [lzsd_pkg::OUT_LEVEL_W-1:0] level_q;
	logic pop;

	assign pop = pop_valid & pop_ready;
	assign pop_valid = (level_q != '0);
	assign pop_res = entry_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lzsd_checker.sv =====
// Port-level assertions for the LZ sequence decompressor and their bind.
`timescale 1ns / 1ps
`default_nettype none

module lzsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Master beat changed while stalled.");

	a_no_bare_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != lzsd_pkg::KIND_DONE)
		else $error("Completion beat without a data byte.");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lzsd_pkg::KIND_ERROR
		|-> m_tdata[7:0] == 8'h00 && m_tdata[11:8] != lzsd_pkg::ERR_NONE)
		else $error("Error beat carries data or no error code.");

	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == lzsd_pkg::KIND_DATA || m_tuser == lzsd_pkg::KIND_LAST)
		|-> m_tdata[11:8] == lzsd_pkg::ERR_NONE && m_tdata[15:12] == 4'h0)
		else $error("Data beat carries an error code.");

	a_final_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready
		&& (m_tuser == lzsd_pkg::KIND_LAST || m_tuser == lzsd_pkg::KIND_ERROR)
		|=> !m_tvalid)
		else $error("A beat followed completion or an error.");

endmodule

bind lz_sequence_decompressor lzsd_checker u_lzsd_checker (.*);

`default_nettype wire
